@@ design/aigsh_pkg.sv @@
`timescale 1ns / 1ps

package aigsh_pkg;

	localparam int TABLE_ENTRIES_DEF = 4096;
	localparam int MAX_PROBES_DEF    = 16;

	localparam logic [31:0] ALL_ONES      = 32'hFFFF_FFFF;
	localparam logic [31:0] HASH_MUL_LOW  = 32'd2000000011;
	localparam logic [31:0] HASH_MUL_HIGH = 32'd2000000033;

	// one table entry as kept in the slot memory
	typedef struct packed {
		logic        valid;
		logic [63:0] key;
		logic [31:0] node;
	} slot_t;

	// request from the probe controller to the hash unit
	typedef struct packed {
		logic        start;
		logic [31:0] lo;
		logic [31:0] hi;
	} hash_req_t;

endpackage

@@ design/aig_structural_hash_lookup.sv @@
// AND-inverter graph structural hash lookup.
// Input channel (in_valid/in_ready): two fanin literals, a proposed node and an
// insert flag. Output channel (out_valid/out_ready): result literal, hit flag
// and table-full flag, exactly one result item per input item, in order.
// Trivial gates (constants, equal inputs, x and not x, undefined input) are
// resolved in the accept cycle and their result is registered; such items
// can stream at one per cycle while the receiver takes every result.
// Other items are hashed (two registered 32-bit multiplies, then the sum)
// and probed in the slot memory, one probe per cycle because of the single
// registered read port. A TABLE_ENTRIES that is not a power of two adds a
// modulo reduction of the hash (8 bits per cycle); a new item is accepted
// only once the result of the previous one has been registered.
// A miss with insert writes the free slot in the last probe cycle unless
// the proposed node is all ones. After reset the block sweeps the memory to
// clear every slot and holds in_ready low meanwhile.
// The finished result sits in an output register; if the receiver stalls, one
// more result is held internally and the block stops accepting until the
// output register drains.
`timescale 1ns / 1ps

module aig_structural_hash_lookup #(
	parameter int TABLE_ENTRIES = aigsh_pkg::TABLE_ENTRIES_DEF,
	parameter int MAX_PROBES    = aigsh_pkg::MAX_PROBES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] left_literal,
	input  logic [31:0] right_literal,
	input  logic [31:0] proposed_node,
	input  logic        do_insert,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] result_literal,
	output logic        found_existing,
	output logic        table_full
);

	import aigsh_pkg::*;

	localparam int IDX_W  = $clog2(TABLE_ENTRIES);
	localparam int SLOT_W = $bits(slot_t);

	hash_req_t          hash_req;
	logic               hash_done;
	logic [IDX_W-1:0]   hash_base;
	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [SLOT_W-1:0]  ram_wdata;
	logic               ram_re;
	logic [IDX_W-1:0]   ram_raddr;
	logic [SLOT_W-1:0]  ram_rdata;

	aigsh_hash #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_hash (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (hash_req),
		.done  (hash_done),
		.base  (hash_base)
	);

	aigsh_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(TABLE_ENTRIES)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	aigsh_ctrl #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.MAX_PROBES   (MAX_PROBES)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.left_literal  (left_literal),
		.right_literal (right_literal),
		.proposed_node (proposed_node),
		.do_insert     (do_insert),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.result_literal(result_literal),
		.found_existing(found_existing),
		.table_full    (table_full),
		.hash_req      (hash_req),
		.hash_done     (hash_done),
		.hash_base     (hash_base),
		.ram_we        (ram_we),
		.ram_waddr     (ram_waddr),
		.ram_wdata     (ram_wdata),
		.ram_re        (ram_re),
		.ram_raddr     (ram_raddr),
		.ram_rdata     (ram_rdata)
	);

endmodule

@@ design/aigsh_ram.sv @@
`timescale 1ns / 1ps

module aigsh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ design/aigsh_hash.sv @@
`timescale 1ns / 1ps

module aigsh_hash #(
	parameter int TABLE_ENTRIES = aigsh_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  aigsh_pkg::hash_req_t             req,
	output logic                             done,
	output logic [$clog2(TABLE_ENTRIES)-1:0] base
);

	import aigsh_pkg::*;

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam bit IS_POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
	localparam logic [IDX_W:0] MOD_N = (IDX_W + 1)'(TABLE_ENTRIES);
	localparam int RED_BITS = 8;

	localparam logic [1:0] H_IDLE = 2'd0;
	localparam logic [1:0] H_MUL  = 2'd1;
	localparam logic [1:0] H_RED  = 2'd2;
	localparam logic [1:0] H_DONE = 2'd3;

	logic [1:0]       state_q;
	logic [1:0]       step_q;
	logic [31:0]      mul_lo_q;
	logic [31:0]      mul_hi_q;
	logic [31:0]      h_q;
	logic [IDX_W-1:0] rem_q;
	logic [31:0]      sum;
	logic [IDX_W:0]   r;
	logic [31:0]      hh;

	assign sum = mul_lo_q + mul_hi_q;

	// eight bits of restoring reduction mod TABLE_ENTRIES per cycle
	always_comb begin
		r  = {1'b0, rem_q};
		hh = h_q;
		for (int k = 0; k < RED_BITS; k++) begin
			r  = {r[IDX_W-1:0], hh[31]};
			hh = {hh[30:0], 1'b0};
			if (r >= MOD_N) begin
				r = r - MOD_N;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				H_IDLE: begin
					if (req.start) begin
						state_q <= H_MUL;
					end
				end
				H_MUL: begin
					step_q  <= '0;
					state_q <= IS_POW2 ? H_DONE : H_RED;
				end
				H_RED: begin
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3) begin
						state_q <= H_DONE;
					end
				end
				H_DONE: begin
					state_q <= H_IDLE;
				end
				default: begin
					state_q <= H_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			H_IDLE: begin
				if (req.start) begin
					mul_lo_q <= HASH_MUL_LOW * req.lo;
					mul_hi_q <= HASH_MUL_HIGH * req.hi;
				end
			end
			H_MUL: begin
				h_q   <= sum;
				rem_q <= IS_POW2 ? sum[IDX_W-1:0] : '0;
			end
			H_RED: begin
				h_q   <= {h_q[31-RED_BITS:0], {RED_BITS{1'b0}}};
				rem_q <= r[IDX_W-1:0];
			end
			default: begin
			end
		endcase
	end

	assign done = state_q == H_DONE;
	assign base = rem_q;

endmodule

@@ design/aigsh_ctrl.sv @@
`timescale 1ns / 1ps

module aigsh_ctrl #(
	parameter int TABLE_ENTRIES = aigsh_pkg::TABLE_ENTRIES_DEF,
	parameter int MAX_PROBES    = aigsh_pkg::MAX_PROBES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [31:0]                      left_literal,
	input  logic [31:0]                      right_literal,
	input  logic [31:0]                      proposed_node,
	input  logic                             do_insert,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [31:0]                      result_literal,
	output logic                             found_existing,
	output logic                             table_full,
	output aigsh_pkg::hash_req_t             hash_req,
	input  logic                             hash_done,
	input  logic [$clog2(TABLE_ENTRIES)-1:0] hash_base,
	output logic                             ram_we,
	output logic [$clog2(TABLE_ENTRIES)-1:0] ram_waddr,
	output logic [$bits(aigsh_pkg::slot_t)-1:0] ram_wdata,
	output logic                             ram_re,
	output logic [$clog2(TABLE_ENTRIES)-1:0] ram_raddr,
	input  logic [$bits(aigsh_pkg::slot_t)-1:0] ram_rdata
);

	import aigsh_pkg::*;

	localparam int IDX_W   = $clog2(TABLE_ENTRIES);
	localparam int PROBE_W = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_HASH  = 3'd2;
	localparam logic [2:0] S_CHECK = 3'd3;
	localparam logic [2:0] S_OUT   = 3'd4;

	logic [2:0]         state_q;
	logic [IDX_W-1:0]   clr_q;
	logic [IDX_W-1:0]   slot_q;
	logic [PROBE_W-1:0] probe_q;
	logic [63:0]        key_q;
	logic [31:0]        prop_q;
	logic               ins_q;
	logic               out_valid_q;
	logic [31:0]        out_lit_q;
	logic               out_found_q;
	logic               out_full_q;
	logic [31:0]        pend_lit_q;
	logic               pend_found_q;
	logic               pend_full_q;

	logic               in_fire;
	logic               out_free;
	logic [31:0]        lo;
	logic [31:0]        hi;
	logic               triv;
	logic [31:0]        triv_lit;
	slot_t              rd_slot;
	slot_t              wr_slot;
	logic               prop_ones;
	logic [31:0]        miss_lit;
	logic               last_probe;
	logic [IDX_W-1:0]   slot_next;
	logic               res_go;
	logic [31:0]        res_lit;
	logic               res_found;
	logic               res_full;

	assign in_ready   = state_q == S_IDLE;
	assign in_fire    = in_valid && in_ready;
	assign out_free   = !out_valid_q || out_ready;
	assign rd_slot    = slot_t'(ram_rdata);
	assign prop_ones  = prop_q == ALL_ONES;
	assign miss_lit   = prop_ones ? ALL_ONES : {prop_q[30:0], 1'b0};
	assign last_probe = probe_q == PROBE_W'(MAX_PROBES - 1);
	assign slot_next  = (slot_q == IDX_W'(TABLE_ENTRIES - 1)) ? '0 : slot_q + 1'b1;

	always_comb begin
		lo = (right_literal < left_literal) ? right_literal : left_literal;
		hi = (right_literal < left_literal) ? left_literal : right_literal;
		triv     = 1'b1;
		triv_lit = '0;
		if (lo == 32'd0) begin
			triv_lit = '0;
		end else if (lo == 32'd1) begin
			triv_lit = hi;
		end else if (lo == hi) begin
			triv_lit = lo;
		end else if (lo[31:1] == hi[31:1]) begin
			// x and not x
			triv_lit = '0;
		end else if (hi == ALL_ONES) begin
			triv_lit = ALL_ONES;
		end else begin
			triv = 1'b0;
		end
	end

	always_comb begin
		hash_req       = '0;
		hash_req.lo    = lo;
		hash_req.hi    = hi;
		ram_we         = 1'b0;
		ram_waddr      = clr_q;
		wr_slot        = '0;
		ram_re         = 1'b0;
		ram_raddr      = slot_next;
		res_go         = 1'b0;
		res_lit        = miss_lit;
		res_found      = 1'b0;
		res_full       = 1'b0;
		case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
			end
			S_IDLE: begin
				if (in_fire) begin
					if (triv) begin
						res_go  = 1'b1;
						res_lit = triv_lit;
					end else begin
						hash_req.start = 1'b1;
					end
				end
			end
			S_HASH: begin
				if (hash_done) begin
					ram_re    = 1'b1;
					ram_raddr = hash_base;
				end
			end
			S_CHECK: begin
				if (!rd_slot.valid) begin
					res_go = 1'b1;
					if (ins_q && !prop_ones) begin
						ram_we        = 1'b1;
						ram_waddr     = slot_q;
						wr_slot.valid = 1'b1;
						wr_slot.key   = key_q;
						wr_slot.node  = prop_q;
					end
				end else if (rd_slot.key == key_q) begin
					res_go    = 1'b1;
					res_lit   = {rd_slot.node[30:0], 1'b0};
					res_found = 1'b1;
				end else if (last_probe) begin
					res_go   = 1'b1;
					res_full = ins_q && !prop_ones;
				end else begin
					ram_re = 1'b1;
				end
			end
			S_OUT: begin
			end
			default: begin
			end
		endcase
	end

	assign ram_wdata = wr_slot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IDX_W'(TABLE_ENTRIES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_fire && !triv) begin
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					if (hash_done) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (res_go) begin
				state_q <= out_free ? S_IDLE : S_OUT;
			end
			if ((res_go || state_q == S_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			key_q  <= {lo, hi};
			prop_q <= proposed_node;
			ins_q  <= do_insert;
		end
		if (state_q == S_HASH) begin
			slot_q  <= hash_base;
			probe_q <= '0;
		end else if (state_q == S_CHECK && ram_re) begin
			slot_q  <= slot_next;
			probe_q <= probe_q + 1'b1;
		end
		if (res_go && out_free) begin
			out_lit_q   <= res_lit;
			out_found_q <= res_found;
			out_full_q  <= res_full;
		end else if (res_go) begin
			pend_lit_q   <= res_lit;
			pend_found_q <= res_found;
			pend_full_q  <= res_full;
		end else if (state_q == S_OUT && out_free) begin
			out_lit_q   <= pend_lit_q;
			out_found_q <= pend_found_q;
			out_full_q  <= pend_full_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign result_literal = out_lit_q;
	assign found_existing = out_found_q;
	assign table_full     = out_full_q;

`ifndef SYNTHESIS
	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_CLEAR || state_q == S_CHECK))
		else $error("slot memory written outside clear or probe");

	a_write_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK && ram_we) |-> !rd_slot.valid)
		else $error("insert overwrote an occupied slot");

	a_hash_wait: assert property (@(posedge clk) disable iff (!arst_n)
		hash_done |-> state_q == S_HASH)
		else $error("hash finished while no item was waiting");

	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> !in_ready)
		else $error("item accepted during clearing pass");

	a_found_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_go |-> !(res_found && res_full))
		else $error("hit reported with full flag");
`endif

endmodule
